// ----- src/bitmap_frame_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Concurrent assertion shorthands shared by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BFA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("bfa: implication check failed");
// next-cycle implication
`define BFA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("bfa: next-cycle check failed");
`else
`define BFA_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define BFA_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ----- src/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared constants, operation and status codes, control types and helpers.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int MAX_FRAMES_DEF = 65536;
  localparam int PAGE_BITS_DEF  = 12;

  localparam int ADDR_W   = 48;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 17;
  localparam int TRACK_W  = 17;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [TRACK_W-1:0] TRACKED_RESET = 17'h10000;
  localparam logic [7:0]         FULL_BYTE     = 8'hFF;
  localparam logic               REG_TRACKED   = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_MARK  = 2'd2,
    FN_INIT  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_READY  = 3'd1,
    ST_NO_MEMORY  = 3'd2,
    ST_MISALIGNED = 3'd3,
    ST_RANGE      = 3'd4,
    ST_FRAME_ZERO = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_MOD,
    S_WSTART,
    S_WALK,
    S_FREE_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    decode;
    logic    init;
    logic    clear;
    logic    mod_init;
    logic    mod_step;
    logic    walk_start;
    logic    walk;
    logic    free_rd;
    logic    free_wr;
    logic    status_we;
    status_t status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  ready;
    logic  count_zero;
    logic  need_mod;
    logic  misaligned;
    logic  out_range;
    logic  frame_zero;
    logic  mark_skip;
    logic  mod_last;
    logic  clr_last;
    logic  hit;
    logic  walk_last;
    logic  out_busy;
  } sts_t;

  function automatic logic [2:0] low_zero(input logic [7:0] v);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) p = 3'(i);
    end
    return p;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'b000, v[i]};
    end
    return c;
  endfunction

endpackage

// ----- src/bitmap_frame_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator unit
// Next-fit page frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in        input      in_valid / in_stall    func, addr, end_addr
//  out       output     out_valid / out_stall  frame_addr, status, free_count
//  config    input      APB psel/penable       tracked_frames at byte address 0
//
//  Refused and failed operations go from decode to the result; free reads the
//  map byte at decode, then writes it. Alloc and mark read map bytes in turn;
//  alloc first takes the next-fit byte modulo the tracked byte count when
//  it lies past the tracked bytes. Init clears the map one byte a cycle.
//  Synchronous reset leaves the map undefined and the unit not ready.
//  A stalled result holds in the output register; the next transaction is
//  accepted meanwhile and waits at its end until the register is free.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit import bfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [ADDR_W-1:0]   addr,
  input  logic [ADDR_W-1:0]   end_addr,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   frame_addr,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  free_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [TRACK_W-1:0] tracked_frames;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TRACKED) ? PDATA_W'(tracked_frames) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_frames <= TRACKED_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TRACKED) begin
      tracked_frames <= pwdata[TRACK_W-1:0];
    end
  end

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfa_dpath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .trk        (tracked_frames),
    .func       (func),
    .addr       (addr),
    .end_addr   (end_addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_addr (frame_addr),
    .status     (status),
    .free_count (free_count)
  );

endmodule

// ----- src/bfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator controller
// Sequences one transaction at a time through decode, map sweeps and result.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_unit_defines.svh"

module bfa_ctrl import bfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.func == FN_INIT) begin
          state_next = S_CLEAR;
        end else if (!sts.ready) begin
          state_next = S_DONE;
        end else begin
          case (sts.func)
            FN_ALLOC: begin
              if (sts.count_zero)    state_next = S_DONE;
              else if (sts.need_mod) state_next = S_MOD;
              else                   state_next = S_WSTART;
            end
            FN_FREE: begin
              if (sts.misaligned || sts.out_range || sts.frame_zero) state_next = S_DONE;
              else state_next = S_FREE_WR;
            end
            FN_MARK: begin
              if (sts.mark_skip) state_next = S_DONE;
              else               state_next = S_WSTART;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (sts.clr_last) state_next = S_DONE;
      end
      S_MOD: begin
        if (sts.mod_last) state_next = S_WSTART;
      end
      S_WSTART: state_next = S_WALK;
      S_WALK: begin
        if ((sts.func == FN_ALLOC && sts.hit) || sts.walk_last) state_next = S_DONE;
      end
      S_FREE_WR: state_next = S_DONE;
      S_DONE: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.func == FN_INIT) begin
          cmd.init = 1'b1;
        end else if (!sts.ready) begin
          cmd.status_we = 1'b1;
          cmd.status    = ST_NOT_READY;
        end else begin
          case (sts.func)
            FN_ALLOC: begin
              if (sts.count_zero) begin
                cmd.status_we = 1'b1;
                cmd.status    = ST_NO_MEMORY;
              end else begin
                cmd.mod_init = 1'b1;
              end
            end
            FN_FREE: begin
              if (sts.misaligned) begin
                cmd.status_we = 1'b1;
                cmd.status    = ST_MISALIGNED;
              end else if (sts.out_range) begin
                cmd.status_we = 1'b1;
                cmd.status    = ST_RANGE;
              end else if (sts.frame_zero) begin
                cmd.status_we = 1'b1;
                cmd.status    = ST_FRAME_ZERO;
              end else begin
                cmd.free_rd = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLEAR:   cmd.clear = 1'b1;
      S_MOD:     cmd.mod_step = 1'b1;
      S_WSTART:  cmd.walk_start = 1'b1;
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.func == FN_ALLOC && sts.walk_last && !sts.hit) begin
          cmd.status_we = 1'b1;
          cmd.status    = ST_NO_MEMORY;
        end
      end
      S_FREE_WR: cmd.free_wr = 1'b1;
      S_DONE:    cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  `BFA_ASSERT_NXT(a_idle_hold, clk, rst, state == S_IDLE && !in_valid, state == S_IDLE)
  `BFA_ASSERT_NXT(a_walk_end, clk, rst, state == S_WALK && sts.walk_last, state == S_DONE)

endmodule

// ----- src/bfa_dpath.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator datapath
// Used map memory, byte walker, next-fit remainder unit, counters, result.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_unit_defines.svh"

module bfa_dpath import bfa_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [TRACK_W-1:0] trk,
  input  logic [FUNC_W-1:0]  func,
  input  logic [ADDR_W-1:0]  addr,
  input  logic [ADDR_W-1:0]  end_addr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ADDR_W-1:0]  frame_addr,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0] free_count
);

  localparam int MAP_BYTES = (MAX_FRAMES + 7) / 8;
  localparam int BYTE_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int FRAME_W   = BYTE_W + 3;
  localparam int TR_W      = FRAME_W + 1;
  localparam int FS_W      = ADDR_W - PAGE_BITS;
  localparam int MCNT_W    = $clog2(BYTE_W + 1);

  logic [7:0] mem [MAP_BYTES];
  logic [7:0] mem_q;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic [BYTE_W-1:0] mem_ra;

  func_t             op_func;
  logic [ADDR_W-1:0] op_addr;
  logic [ADDR_W-1:0] op_end;

  logic               ready;
  logic [COUNT_W-1:0] free_cnt;
  logic [BYTE_W-1:0]  next_fit;

  logic [BYTE_W-1:0]  clr_ptr;
  logic [BYTE_W-1:0]  mod_rem;
  logic [BYTE_W-1:0]  mod_sh;
  logic [MCNT_W-1:0]  mod_cnt;
  logic [BYTE_W-1:0]  walk_ptr;
  logic [BYTE_W:0]    walk_left;
  logic               data_vld;
  logic               data_last;
  logic [BYTE_W-1:0]  data_byte;
  logic [FRAME_W-1:0] mk_fs;
  logic [FRAME_W-1:0] mk_last;

  status_t           res_status;
  logic [ADDR_W-1:0] res_faddr;

  logic [TR_W-1:0]    tr;
  logic [TR_W-1:0]    tr_p7;
  logic [BYTE_W:0]    nbytes;
  logic [BYTE_W:0]    nbytes_m1;
  logic [BYTE_W:0]    mod_pair;
  logic [BYTE_W:0]    ptr_inc;
  logic [BYTE_W-1:0]  ptr_wrap;
  logic               issue;
  logic [7:0]         vmask;
  logic [7:0]         v_eff;
  logic [2:0]         hit_pos;
  logic               alloc_hit;
  logic [FS_W-1:0]    fidx;
  logic [FS_W:0]      fe_full;
  logic [TR_W-1:0]    fe_c;
  logic [TR_W-1:0]    fe_m1;
  logic [FRAME_W-1:0] free_frame;
  logic [7:0]         free_bit;
  logic [BYTE_W-1:0]  mk_first_b;
  logic [BYTE_W-1:0]  mk_last_b;
  logic [7:0]         mk_lo;
  logic [7:0]         mk_hi;
  logic [7:0]         mk_mask;
  logic [3:0]         mk_new;
  logic               mark_act;
  logic [BYTE_W-1:0]  ws_ptr;
  logic [BYTE_W:0]    ws_cnt;

  always_comb begin
    if (trk == '0) begin
      tr = TR_W'(1);
    end else if (32'(trk) > 32'(MAX_FRAMES)) begin
      tr = TR_W'(MAX_FRAMES);
    end else begin
      tr = TR_W'(trk);
    end
    tr_p7     = tr + TR_W'(7);
    nbytes    = tr_p7[TR_W-1:3];
    nbytes_m1 = nbytes - (BYTE_W+1)'(1);

    mod_pair = {mod_rem, mod_sh[BYTE_W-1]};
    ptr_inc  = {1'b0, walk_ptr} + (BYTE_W+1)'(1);
    ptr_wrap = (ptr_inc == nbytes) ? '0 : ptr_inc[BYTE_W-1:0];
    issue    = cmd.walk && (walk_left != '0);

    if (data_byte == nbytes_m1[BYTE_W-1:0] && tr[2:0] != 3'd0) begin
      vmask = FULL_BYTE >> (4'd8 - {1'b0, tr[2:0]});
    end else begin
      vmask = FULL_BYTE;
    end
    v_eff     = mem_q | ~vmask;
    hit_pos   = low_zero(v_eff);
    alloc_hit = data_vld && (op_func == FN_ALLOC) && (v_eff != FULL_BYTE);

    fidx       = op_addr[ADDR_W-1:PAGE_BITS];
    fe_full    = {1'b0, op_end[ADDR_W-1:PAGE_BITS]} + (FS_W+1)'(|op_end[PAGE_BITS-1:0]);
    fe_c       = (fe_full > (FS_W+1)'(tr)) ? tr : fe_full[TR_W-1:0];
    fe_m1      = fe_c - TR_W'(1);
    free_frame = fidx[FRAME_W-1:0];
    free_bit   = 8'd1 << free_frame[2:0];

    mk_first_b = mk_fs[FRAME_W-1:3];
    mk_last_b  = mk_last[FRAME_W-1:3];
    mk_lo      = (data_byte == mk_first_b) ? (FULL_BYTE << mk_fs[2:0]) : FULL_BYTE;
    mk_hi      = (data_byte == mk_last_b) ? (FULL_BYTE >> (3'd7 - mk_last[2:0])) : FULL_BYTE;
    mk_mask    = mk_lo & mk_hi;
    mk_new     = pop8(mk_mask & ~mem_q);
    mark_act   = cmd.walk && data_vld && (op_func == FN_MARK);

    if (op_func == FN_ALLOC) begin
      ws_ptr = mod_rem;
      ws_cnt = nbytes;
    end else begin
      ws_ptr = mk_first_b;
      ws_cnt = {1'b0, mk_last_b} - {1'b0, mk_first_b} + (BYTE_W+1)'(1);
    end

    mem_ra = cmd.free_rd ? free_frame[FRAME_W-1:3] : walk_ptr;
    mem_we = 1'b0;
    mem_wa = walk_ptr;
    mem_wd = 8'h00;
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_ptr;
    end else if (cmd.walk && alloc_hit) begin
      mem_we = 1'b1;
      mem_wa = data_byte;
      mem_wd = mem_q | (8'd1 << hit_pos);
    end else if (mark_act) begin
      mem_we = 1'b1;
      mem_wa = data_byte;
      mem_wd = mem_q | mk_mask;
    end else if (cmd.free_wr && (mem_q & free_bit) != 8'h00) begin
      mem_we = 1'b1;
      mem_wa = free_frame[FRAME_W-1:3];
      mem_wd = mem_q & ~free_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= func_t'(func);
      op_addr <= addr;
      op_end  <= end_addr;
    end
    if (cmd.decode) begin
      mk_fs   <= fidx[FRAME_W-1:0];
      mk_last <= fe_m1[FRAME_W-1:0];
    end
    if (cmd.init) begin
      clr_ptr <= '0;
    end else if (cmd.clear) begin
      clr_ptr <= clr_ptr + BYTE_W'(1);
    end
    if (cmd.mod_init) begin
      mod_rem <= sts.need_mod ? '0 : next_fit;
      mod_sh  <= next_fit;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      mod_rem <= (mod_pair >= nbytes) ? BYTE_W'(mod_pair - nbytes) : mod_pair[BYTE_W-1:0];
      mod_sh  <= mod_sh << 1;
      mod_cnt <= mod_cnt + MCNT_W'(1);
    end
    if (cmd.walk_start) begin
      walk_ptr  <= ws_ptr;
      walk_left <= ws_cnt;
    end else if (issue) begin
      walk_ptr  <= ptr_wrap;
      walk_left <= walk_left - (BYTE_W+1)'(1);
    end
    data_byte <= walk_ptr;
    data_last <= (walk_left == (BYTE_W+1)'(1));
    if (cmd.load) begin
      res_status <= ST_OK;
      res_faddr  <= '0;
    end else begin
      if (cmd.status_we) res_status <= cmd.status;
      if (cmd.walk && alloc_hit) res_faddr <= ADDR_W'({data_byte, hit_pos}) << PAGE_BITS;
    end
    if (cmd.out_load) begin
      frame_addr <= res_faddr;
      status     <= res_status;
      free_count <= free_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready     <= 1'b0;
      free_cnt  <= '0;
      next_fit  <= '0;
      data_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      data_vld <= cmd.walk_start ? 1'b0 : issue;
      if (cmd.init) begin
        ready    <= 1'b1;
        free_cnt <= COUNT_W'(tr);
      end else if (cmd.walk && alloc_hit) begin
        free_cnt <= free_cnt - COUNT_W'(1);
        next_fit <= data_byte;
      end else if (mark_act) begin
        free_cnt <= (free_cnt < COUNT_W'(mk_new)) ? '0 : free_cnt - COUNT_W'(mk_new);
      end else if (cmd.free_wr && (mem_q & free_bit) != 8'h00 && free_cnt != COUNT_MAX) begin
        free_cnt <= free_cnt + COUNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.func       = op_func;
    sts.ready      = ready;
    sts.count_zero = (free_cnt == '0);
    sts.need_mod   = ({1'b0, next_fit} >= nbytes);
    sts.misaligned = |op_addr[PAGE_BITS-1:0];
    sts.out_range  = (fidx >= FS_W'(tr));
    sts.frame_zero = (fidx == '0);
    sts.mark_skip  = (op_end <= op_addr) || (fidx >= FS_W'(tr));
    sts.mod_last   = (mod_cnt == MCNT_W'(BYTE_W - 1));
    sts.clr_last   = (clr_ptr == BYTE_W'(MAP_BYTES - 1));
    sts.hit        = alloc_hit;
    sts.walk_last  = data_vld && data_last;
    sts.out_busy   = out_valid && out_stall;
  end

  `BFA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !(out_valid && out_stall))
  `BFA_ASSERT_NXT(a_hit_count, clk, rst, cmd.walk && alloc_hit, free_cnt == $past(free_cnt) - 1'b1)
  `BFA_ASSERT_IMP(a_fail_no_addr, clk, rst, cmd.out_load && res_status != ST_OK, res_faddr == '0)

endmodule
